>>> design/rational_add_sub_compare_macros.svh
// Assertion macros used by the checker of this block.
`ifndef RATIONAL_ADD_SUB_COMPARE_MACROS_SVH
`define RATIONAL_ADD_SUB_COMPARE_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define RASC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that an antecedent is followed in the next cycle by a consequent.
`define RASC_ASSERT_NEXT(lbl, ante, cons, msg) \
  `RASC_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

>>> design/rasc_pkg.sv
`default_nettype none
package rasc_pkg;

  localparam int DataWidthDef = 32;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_CMP = 2'd2,
    CMD_RED = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZDEN = 2'd1,
    ST_OVF  = 2'd2
  } status_e;

endpackage
`default_nettype wire

>>> design/rational_add_sub_compare.sv
// Fractions are reduced on the shared 2*OPW-bit divider (OPW = DATA_WIDTH limited to 8..32)
// by Euclid remainder steps and then the two final divisions of numerator and denominator
// by the GCD; a zero numerator skips the divider. A transaction with no zero denominator
// reduces one to three fractions: a, then b, then the sum or difference.
// Throughput: one transaction at a time; busy stays high until the result strobe.
// Reset: asynchronous, active low; clears the sequencer, the result strobe and all top-level registers.
// The result is shown for one cycle on valid_o; the receiver cannot stall.
`default_nettype none
module rational_add_sub_compare #(
  parameter int DATA_WIDTH = rasc_pkg::DataWidthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  command_i,
  input  wire logic [31:0] a_num_i,
  input  wire logic [31:0] a_den_i,
  input  wire logic [31:0] b_num_i,
  input  wire logic [31:0] b_den_i,
  output logic             valid_o,
  output logic [31:0]      res_num_o,
  output logic [30:0]      res_den_o,
  output logic             is_equal_o,
  output logic [1:0]       status_o
);

  localparam int OPW = (DATA_WIDTH < 8) ? 8 : ((DATA_WIDTH > 32) ? 32 : DATA_WIDTH);
  localparam int WW  = 2 * OPW;
  localparam logic [WW-1:0] NegMax = WW'(1) << (OPW - 1);
  localparam logic [WW-1:0] PosMax = NegMax - WW'(1);

  typedef enum logic [3:0] {
    S_IDLE, S_ERR, S_NORM, S_GCD, S_GCDW, S_QMW, S_QDW, S_NDONE,
    S_M1, S_M2, S_M3, S_SUM, S_FIN
  } state_e;

  typedef enum logic [1:0] {
    PH_A, PH_B, PH_R
  } phase_e;

  function automatic logic [OPW-1:0] mag_of(input logic [OPW-1:0] v);
    mag_of = v[OPW-1] ? (~v + 1'b1) : v;
  endfunction

  state_e          state_q;
  phase_e          phase_q;
  rasc_pkg::cmd_e  cmd_q;
  logic [OPW-1:0]  b_num_q, b_den_q;
  logic            n_neg_q;
  logic [WW-1:0]   n_mag_q, n_den_q, gx_q, gy_q;
  logic            a_neg_q;
  logic [OPW-1:0]  a_mag_q, a_den_q, b_mag_q, b_dn_q;
  logic            b_neg_q;
  logic [WW-1:0]   t1_q, t2_q, pd_q;
  logic            div_start_q;
  logic [WW-1:0]   div_dend_q, div_dsor_q;
  logic            div_done;
  logic [WW-1:0]   div_quo, div_rem;
  logic            valid_q, eq_q;
  logic [31:0]     res_num_q;
  logic [30:0]     res_den_q;
  rasc_pkg::status_e st_q;

  logic [OPW-1:0]  mul_x, mul_y;
  logic [WW-1:0]   mul_p;
  logic            bneg;
  logic [31:0]     mag32;
  logic            fits;

  rasc_div #(.W(WW)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start_q),
    .dividend_i  (div_dend_q),
    .divisor_i   (div_dsor_q),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  always_comb begin
    unique case (state_q)
      S_M1:    begin mul_x = a_mag_q; mul_y = b_dn_q;  end
      S_M2:    begin mul_x = b_mag_q; mul_y = a_den_q; end
      default: begin mul_x = a_den_q; mul_y = b_dn_q;  end
    endcase
    mul_p = WW'(mul_x) * WW'(mul_y);
    bneg  = (cmd_q == rasc_pkg::CMD_SUB) ? !b_neg_q : b_neg_q;
    mag32 = 32'(n_mag_q);
    fits  = (n_den_q <= PosMax) && (n_neg_q ? (n_mag_q <= NegMax) : (n_mag_q <= PosMax));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_A;
      div_start_q <= 1'b0;
      valid_q     <= 1'b0;
      cmd_q       <= rasc_pkg::CMD_ADD;
      b_num_q     <= '0;
      b_den_q     <= '0;
      n_neg_q     <= 1'b0;
      n_mag_q     <= '0;
      n_den_q     <= '0;
      gx_q        <= '0;
      gy_q        <= '0;
      a_neg_q     <= 1'b0;
      a_mag_q     <= '0;
      a_den_q     <= '0;
      b_neg_q     <= 1'b0;
      b_mag_q     <= '0;
      b_dn_q      <= '0;
      t1_q        <= '0;
      t2_q        <= '0;
      pd_q        <= '0;
      div_dend_q  <= '0;
      div_dsor_q  <= '0;
      eq_q        <= 1'b0;
      res_num_q   <= '0;
      res_den_q   <= '0;
      st_q        <= rasc_pkg::ST_OK;
    end else begin
      div_start_q <= 1'b0;
      valid_q     <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            cmd_q   <= rasc_pkg::cmd_e'(command_i);
            b_num_q <= b_num_i[OPW-1:0];
            b_den_q <= b_den_i[OPW-1:0];
            phase_q <= PH_A;
            n_neg_q <= a_num_i[OPW-1] != a_den_i[OPW-1];
            n_mag_q <= WW'(mag_of(a_num_i[OPW-1:0]));
            n_den_q <= WW'(mag_of(a_den_i[OPW-1:0]));
            if (a_den_i[OPW-1:0] == '0 ||
                (rasc_pkg::cmd_e'(command_i) != rasc_pkg::CMD_RED &&
                 b_den_i[OPW-1:0] == '0)) begin
              state_q <= S_ERR;
            end else begin
              state_q <= S_NORM;
            end
          end
        end
        S_ERR: begin
          res_num_q <= '0;
          res_den_q <= 31'd1;
          eq_q      <= 1'b0;
          st_q      <= rasc_pkg::ST_ZDEN;
          valid_q   <= 1'b1;
          state_q   <= S_IDLE;
        end
        S_NORM: begin
          if (n_mag_q == '0) begin
            n_neg_q <= 1'b0;
            n_den_q <= WW'(1);
            state_q <= S_NDONE;
          end else begin
            gx_q    <= n_mag_q;
            gy_q    <= n_den_q;
            state_q <= S_GCD;
          end
        end
        S_GCD: begin
          div_start_q <= 1'b1;
          if (gx_q == '0 || gy_q == '0) begin
            gy_q       <= gx_q | gy_q;
            div_dend_q <= n_mag_q;
            div_dsor_q <= gx_q | gy_q;
            state_q    <= S_QMW;
          end else begin
            div_dend_q <= (gx_q >= gy_q) ? gx_q : gy_q;
            div_dsor_q <= (gx_q >= gy_q) ? gy_q : gx_q;
            state_q    <= S_GCDW;
          end
        end
        S_GCDW: begin
          if (div_done) begin
            if (gx_q >= gy_q) begin
              gx_q <= div_rem;
            end else begin
              gy_q <= div_rem;
            end
            state_q <= S_GCD;
          end
        end
        S_QMW: begin
          if (div_done) begin
            n_mag_q     <= div_quo;
            div_start_q <= 1'b1;
            div_dend_q  <= n_den_q;
            div_dsor_q  <= gy_q;
            state_q     <= S_QDW;
          end
        end
        S_QDW: begin
          if (div_done) begin
            n_den_q <= div_quo;
            state_q <= S_NDONE;
          end
        end
        S_NDONE: begin
          unique case (phase_q)
            PH_A: begin
              a_neg_q <= n_neg_q;
              a_mag_q <= n_mag_q[OPW-1:0];
              a_den_q <= n_den_q[OPW-1:0];
              if (cmd_q == rasc_pkg::CMD_RED) begin
                state_q <= S_FIN;
              end else begin
                phase_q <= PH_B;
                n_neg_q <= b_num_q[OPW-1] != b_den_q[OPW-1];
                n_mag_q <= WW'(mag_of(b_num_q));
                n_den_q <= WW'(mag_of(b_den_q));
                state_q <= S_NORM;
              end
            end
            PH_B: begin
              b_neg_q <= n_neg_q;
              b_mag_q <= n_mag_q[OPW-1:0];
              b_dn_q  <= n_den_q[OPW-1:0];
              if (cmd_q == rasc_pkg::CMD_CMP) begin
                res_num_q <= '0;
                res_den_q <= 31'd1;
                eq_q      <= (a_neg_q == n_neg_q) && (WW'(a_mag_q) == n_mag_q) &&
                             (WW'(a_den_q) == n_den_q);
                st_q      <= rasc_pkg::ST_OK;
                valid_q   <= 1'b1;
                state_q   <= S_IDLE;
              end else begin
                state_q <= S_M1;
              end
            end
            default: state_q <= S_FIN;
          endcase
        end
        S_M1: begin
          t1_q    <= mul_p;
          state_q <= S_M2;
        end
        S_M2: begin
          t2_q    <= mul_p;
          state_q <= S_M3;
        end
        S_M3: begin
          pd_q    <= mul_p;
          state_q <= S_SUM;
        end
        S_SUM: begin
          if (a_neg_q == bneg) begin
            n_mag_q <= t1_q + t2_q;
            n_neg_q <= a_neg_q;
          end else if (t1_q >= t2_q) begin
            n_mag_q <= t1_q - t2_q;
            n_neg_q <= a_neg_q;
          end else begin
            n_mag_q <= t2_q - t1_q;
            n_neg_q <= bneg;
          end
          n_den_q <= pd_q;
          phase_q <= PH_R;
          state_q <= S_NORM;
        end
        S_FIN: begin
          eq_q <= 1'b0;
          if (fits) begin
            res_num_q <= n_neg_q ? (~mag32 + 32'd1) : mag32;
            res_den_q <= 31'(n_den_q);
            st_q      <= rasc_pkg::ST_OK;
          end else begin
            res_num_q <= '0;
            res_den_q <= 31'd1;
            st_q      <= rasc_pkg::ST_OVF;
          end
          valid_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy       = state_q != S_IDLE;
  assign valid_o    = valid_q;
  assign res_num_o  = res_num_q;
  assign res_den_o  = res_den_q;
  assign is_equal_o = eq_q;
  assign status_o   = st_q;

endmodule
`default_nettype wire

>>> design/rasc_div.sv
`default_nettype none
module rasc_div #(
  parameter int W = 64
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] dividend_i,
  input  wire logic [W-1:0] divisor_i,
  output logic              done_o,
  output logic [W-1:0]      quotient_o,
  output logic [W-1:0]      remainder_o
);

  localparam int CntW = $clog2(W + 1);

  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    quo_q, quo_d;
  logic [W-1:0]    dsor_q;
  logic [CntW-1:0] cnt_q;
  logic            run_q, done_q;
  logic [W:0]      sh;
  logic [W:0]      diff;
  logic            ge;

  always_comb begin
    sh    = {rem_q, quo_q[W-1]};
    diff  = sh - {1'b0, dsor_q};
    ge    = sh >= {1'b0, dsor_q};
    rem_d = ge ? diff[W-1:0] : sh[W-1:0];
    quo_d = {quo_q[W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(W);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quo_q  <= dividend_i;
      dsor_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule
`default_nettype wire

>>> design/rasc_checker.sv
`default_nettype none
`include "rational_add_sub_compare_macros.svh"
module rasc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        valid_o,
  input wire logic [31:0] res_num_o,
  input wire logic [30:0] res_den_o,
  input wire logic        is_equal_o,
  input wire logic [1:0]  status_o
);

  `RASC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction not busy")
  `RASC_ASSERT(a_valid_idle, valid_o |-> !busy, "result strobe while busy")
  `RASC_ASSERT_NEXT(a_valid_single, valid_o, !valid_o, "result strobe longer than one cycle")
  `RASC_ASSERT(a_err_zero,
    valid_o && status_o != rasc_pkg::ST_OK |->
      res_num_o == 32'd0 && res_den_o == 31'd1 && !is_equal_o,
    "error result not cleared")
  `RASC_ASSERT(a_den_pos, valid_o |-> res_den_o != 31'd0 && status_o != 2'd3,
    "bad denominator or status")

endmodule

bind rational_add_sub_compare rasc_checker u_rasc_checker (.*);
`default_nettype wire

>>> bench/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned CycleLimit = 64'd60_000_000;
  localparam longint unsigned Pos32Max = 64'h7FFF_FFFF;
  localparam longint unsigned Neg32Max = 64'h8000_0000;

  typedef struct packed {
    logic [31:0]       num;
    logic [30:0]       den;
    logic              eq;
    rasc_pkg::status_e st;
  } quotient_t;

  typedef struct {
    logic            neg;
    longint unsigned mag;
    longint unsigned den;
  } ratio_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command_i = '0;
  logic [31:0] a_num_i = '0;
  logic [31:0] a_den_i = '0;
  logic [31:0] b_num_i = '0;
  logic [31:0] b_den_i = '0;
  logic        valid_o;
  logic [31:0] res_num_o;
  logic [30:0] res_den_o;
  logic        is_equal_o;
  logic [1:0]  status_o;

  quotient_t       pending_q[$];
  int unsigned     mismatch_count = 0;
  longint unsigned cycle_count = 0;
  bit              no_idle = 1'b0;

  rational_add_sub_compare u_top (
    .clk_i, .rst_ni, .start, .busy, .command_i, .a_num_i, .a_den_i, .b_num_i,
    .b_den_i, .valid_o, .res_num_o, .res_den_o, .is_equal_o, .status_o
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic longint unsigned euclid(longint unsigned x, longint unsigned y);
    while (x != 0 && y != 0) begin
      if (x >= y) x = x % y;
      else y = y % x;
    end
    return x | y;
  endfunction

  function automatic ratio_t lowest_terms(logic neg, longint unsigned mag,
                                          longint unsigned den);
    ratio_t r;
    longint unsigned g;
    if (mag == 0) begin
      r.neg = 1'b0;
      r.mag = 0;
      r.den = 1;
      return r;
    end
    g = euclid(mag, den);
    r.neg = neg;
    r.mag = mag / g;
    r.den = den / g;
    return r;
  endfunction

  function automatic longint unsigned magnitude(logic [31:0] x);
    logic [31:0] m;
    m = x[31] ? -x : x;
    return {32'd0, m};
  endfunction

  function automatic ratio_t to_ratio(logic [31:0] n, logic [31:0] d);
    return lowest_terms(n[31] != d[31], magnitude(n), magnitude(d));
  endfunction

  function automatic quotient_t predict_quotient(rasc_pkg::cmd_e cmd, logic [31:0] an,
                                                 logic [31:0] ad, logic [31:0] bn,
                                                 logic [31:0] bd);
    quotient_t q;
    ratio_t a, b, r;
    longint unsigned t1, t2;
    logic bneg;
    q = '{num: '0, den: 31'd1, eq: 1'b0, st: rasc_pkg::ST_OK};
    if (ad == 0 || (cmd != rasc_pkg::CMD_RED && bd == 0)) begin
      q.st = rasc_pkg::ST_ZDEN;
      return q;
    end
    a = to_ratio(an, ad);
    b = to_ratio(bn, bd);
    if (cmd == rasc_pkg::CMD_CMP) begin
      q.eq = (a.neg == b.neg && a.mag == b.mag && a.den == b.den);
      return q;
    end
    if (cmd == rasc_pkg::CMD_RED) begin
      r = a;
    end else begin
      t1 = a.mag * b.den;
      t2 = b.mag * a.den;
      bneg = (cmd == rasc_pkg::CMD_SUB) ? !b.neg : b.neg;
      if (a.neg == bneg) r = lowest_terms(a.neg, t1 + t2, a.den * b.den);
      else if (t1 >= t2) r = lowest_terms(a.neg, t1 - t2, a.den * b.den);
      else r = lowest_terms(bneg, t2 - t1, a.den * b.den);
    end
    if (r.den <= Pos32Max && (r.neg ? r.mag <= Neg32Max : r.mag <= Pos32Max)) begin
      q.num = r.neg ? -r.mag[31:0] : r.mag[31:0];
      q.den = r.den[30:0];
    end else begin
      q.st = rasc_pkg::ST_OVF;
    end
    return q;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    quotient_t want;
    if (rst_ni && valid_o) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected transaction", res_num_o, '0);
      end else begin
        want = pending_q.pop_front();
        if (res_num_o !== want.num) report_mismatch("res_num", res_num_o, want.num);
        if (res_den_o !== want.den) begin
          report_mismatch("res_den", 32'(res_den_o), 32'(want.den));
        end
        if (is_equal_o !== want.eq) begin
          report_mismatch("is_equal", 32'(is_equal_o), 32'(want.eq));
        end
        if (status_o !== want.st) begin
          report_mismatch("status", 32'(status_o), 32'(want.st));
        end
      end
    end
  end

  task automatic send_fraction_pair(rasc_pkg::cmd_e cmd, logic [31:0] an, logic [31:0] ad,
                                    logic [31:0] bn, logic [31:0] bd);
    int unsigned gap;
    start <= 1'b1;
    command_i <= cmd;
    a_num_i <= an;
    a_den_i <= ad;
    b_num_i <= bn;
    b_den_i <= bd;
    do @(posedge clk_i); while (busy);
    pending_q.push_back(predict_quotient(cmd, an, ad, bn, bd));
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_operand(bit nonzero);
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 60) * (1 << $urandom_range(0, 3));
      4, 5:       v = $urandom_range(0, 5000);
      6:          v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default:    v = $urandom;
    endcase
    if ($urandom_range(0, 1)) v = -v;
    if (nonzero && v == 0) v = 1;
    return v;
  endfunction

  task automatic test_directed();
    rasc_pkg::cmd_e cmd;
    send_fraction_pair(rasc_pkg::CMD_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_fraction_pair(rasc_pkg::CMD_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
    send_fraction_pair(rasc_pkg::CMD_SUB, 32'd1, 32'd3, 32'd1, 32'd2);
    send_fraction_pair(rasc_pkg::CMD_CMP, 32'd2, 32'd4, -32'd3, -32'd6);
    send_fraction_pair(rasc_pkg::CMD_CMP, 32'd2, 32'd4, 32'd3, -32'd6);
    send_fraction_pair(rasc_pkg::CMD_CMP, 32'd0, 32'd5, 32'd0, -32'd7);
    send_fraction_pair(rasc_pkg::CMD_RED, 32'd12, -32'd18, 32'd0, 32'd0);
    send_fraction_pair(rasc_pkg::CMD_RED, 32'd0, -32'd9, 32'd5, 32'd0);
    send_fraction_pair(rasc_pkg::CMD_RED, 32'h8000_0000, -32'd1, 32'd1, 32'd1);
    send_fraction_pair(rasc_pkg::CMD_RED, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
    send_fraction_pair(rasc_pkg::CMD_RED, 32'h8000_0000, 32'h8000_0000, 32'd1, 32'd1);
    send_fraction_pair(rasc_pkg::CMD_RED, 32'd5, 32'h8000_0000, 32'd1, 32'd1);
    send_fraction_pair(rasc_pkg::CMD_RED, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1, 32'd1);
    send_fraction_pair(rasc_pkg::CMD_ADD, 32'h7FFF_FFFF, 32'd1, 32'd1, 32'd1);
    send_fraction_pair(rasc_pkg::CMD_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
    send_fraction_pair(rasc_pkg::CMD_SUB, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
    send_fraction_pair(rasc_pkg::CMD_ADD, 32'd1, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFE);
    send_fraction_pair(rasc_pkg::CMD_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h8000_0000);
    send_fraction_pair(rasc_pkg::CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd3);
    for (int i = 0; i < 4; i++) begin
      cmd = rasc_pkg::cmd_e'(i);
      send_fraction_pair(cmd, 32'd3, 32'd0, 32'd1, 32'd2);
      send_fraction_pair(cmd, 32'd3, 32'd4, 32'd1, 32'd0);
    end
    drain_results();
  endtask

  task automatic test_random();
    rasc_pkg::cmd_e cmd;
    logic [31:0] an, ad, bn, bd;
    for (int i = 0; i < 730; i++) begin
      if (i % 100 == 0) no_idle = $urandom_range(0, 2) == 0;
      if (i == 365) drain_results();
      cmd = rasc_pkg::cmd_e'($urandom_range(0, 3));
      an = pick_operand(1'b0);
      ad = pick_operand($urandom_range(0, 19) != 0);
      if (cmd == rasc_pkg::CMD_CMP && $urandom_range(0, 1)) begin
        bn = an * 32'd3;
        bd = ad * 32'd3;
        if ($urandom_range(0, 1)) begin
          bn = -bn;
          bd = -bd;
        end
      end else begin
        bn = pick_operand(1'b0);
        bd = pick_operand($urandom_range(0, 19) != 0);
      end
      send_fraction_pair(cmd, an, ad, bn, bd);
    end
    drain_results();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> rational_add_sub_compare.f
+incdir+design
design/rasc_pkg.sv
design/rasc_div.sv
design/rational_add_sub_compare.sv
design/rasc_checker.sv
bench/tb.sv
